### src/mnre_pkg.sv
// Shared constants and types for the MIDI note encoder with per-key counting.
`timescale 1ns / 1ps

package mnre_pkg;

    localparam int KEY_COUNT_DEF = 128;
    localparam int KEY_W         = 7;
    localparam int CHAN_W        = 4;
    localparam int VALUE_W       = 8;
    localparam int COUNT_W       = 8;
    localparam int FIFO_DEPTH    = 2;

    localparam logic [1:0] MODE_NOTE_ON  = 2'd0;
    localparam logic [1:0] MODE_NOTE_OFF = 2'd1;
    localparam logic [1:0] MODE_PRESSURE = 2'd2;

    localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
    localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
    localparam logic [7:0] STATUS_PRESSURE = 8'hD0;
    localparam logic [7:0] MASK_CHANNEL    = 8'h0F;
    localparam logic [7:0] MASK_DATA       = 8'h7F;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [7:0] status;
        logic [6:0] data1;
        logic [6:0] data2;
        logic       two_bytes;
    } msg_t;

endpackage

### src/mnre_front.sv
// Front end: accepts requests, updates per-key counters and queues messages.
`timescale 1ns / 1ps

module mnre_front
    import mnre_pkg::*;
#(
    parameter int KEY_COUNT = KEY_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [CHAN_W-1:0]  cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         mode,
    input  logic [CHAN_W-1:0]  channel,
    input  logic [KEY_W-1:0]   key,
    input  logic [VALUE_W-1:0] value,
    input  logic               fifo_full,
    output logic               push,
    output msg_t               push_msg
);

    localparam int IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    state_t             st_reg;
    logic [CHAN_W-1:0]  counted_channel_reg;
    logic [1:0]         mode_reg;
    logic [CHAN_W-1:0]  channel_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VALUE_W-1:0] value_reg;
    logic               counted_reg;
    logic [IDX_W-1:0]   idx_reg;

    logic [COUNT_W-1:0] count_mem [KEY_COUNT];
    logic [KEY_COUNT-1:0] vld_reg;
    logic [COUNT_W-1:0] rd_data_reg;
    logic               rd_vld_reg;

    logic               accept;
    logic [IDX_W-1:0]   in_idx;
    logic               in_counted;
    logic [COUNT_W-1:0] cur_cnt;
    logic [COUNT_W-1:0] wr_cnt;
    logic               wr_en;
    logic [7:0]         chan_byte;

    assign accept     = in_valid && in_ready;
    assign in_ready   = (st_reg == ST_IDLE) && !fifo_full;
    assign in_idx     = key[IDX_W-1:0];
    assign in_counted = (channel == counted_channel_reg)
                        && ({1'b0, key} < (KEY_W + 1)'(KEY_COUNT));
    assign cur_cnt    = rd_vld_reg ? rd_data_reg : '0;
    assign chan_byte  = {4'h0, channel_reg} & MASK_CHANNEL;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            st_reg              <= ST_IDLE;
            counted_channel_reg <= '0;
            mode_reg            <= MODE_NOTE_ON;
            channel_reg         <= '0;
            key_reg             <= '0;
            value_reg           <= '0;
            counted_reg         <= 1'b0;
            idx_reg             <= '0;
        end else begin
            if (cfg_wr_en) begin
                counted_channel_reg <= cfg_wr_data;
            end
            unique case (st_reg)
                ST_IDLE: begin
                    if (accept) begin
                        st_reg      <= ST_LOOKUP;
                        mode_reg    <= mode;
                        channel_reg <= channel;
                        key_reg     <= key;
                        value_reg   <= value;
                        counted_reg <= in_counted;
                        idx_reg     <= in_idx;
                    end
                end
                ST_LOOKUP: begin
                    st_reg <= ST_IDLE;
                end
                default: begin
                    st_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            rd_data_reg <= count_mem[in_idx];
        end
        if (wr_en) begin
            count_mem[idx_reg] <= wr_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (accept) begin
                rd_vld_reg <= vld_reg[in_idx];
            end
            if (wr_en) begin
                vld_reg[idx_reg] <= 1'b1;
            end
        end
    end

    always_comb begin
        wr_en              = 1'b0;
        wr_cnt             = cur_cnt;
        push               = 1'b0;
        push_msg.status    = STATUS_NOTE_ON | chan_byte;
        push_msg.data1     = key_reg & MASK_DATA[6:0];
        push_msg.data2     = value_reg[6:0];
        push_msg.two_bytes = 1'b0;
        if (st_reg == ST_LOOKUP) begin
            unique case (mode_reg)
                MODE_NOTE_ON: begin
                    push = 1'b1;
                    if (counted_reg && cur_cnt != COUNT_MAX) begin
                        wr_en  = 1'b1;
                        wr_cnt = cur_cnt + 1'b1;
                    end
                end
                MODE_NOTE_OFF: begin
                    push_msg.status = STATUS_NOTE_OFF | chan_byte;
                    if (counted_reg) begin
                        if (cur_cnt != '0) begin
                            wr_en  = 1'b1;
                            wr_cnt = cur_cnt - 1'b1;
                        end
                        push = (cur_cnt == '0) || (cur_cnt == COUNT_W'(1));
                    end else begin
                        push = 1'b1;
                    end
                end
                MODE_PRESSURE: begin
                    push               = 1'b1;
                    push_msg.status    = STATUS_PRESSURE | chan_byte;
                    push_msg.data1     = value_reg[6:0];
                    push_msg.two_bytes = 1'b1;
                end
                default: begin
                    push = 1'b0;
                end
            endcase
        end
    end

    a_lookup_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == ST_LOOKUP |-> $past(in_valid && in_ready))
        else $error("lookup without accepted word");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !fifo_full)
        else $error("push into full queue");

endmodule

### src/mnre_fifo.sv
// Short message queue between the front and back ends.
`timescale 1ns / 1ps

module mnre_fifo
    import mnre_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  msg_t push_msg,
    input  logic pop,
    output msg_t pop_msg,
    output logic empty,
    output logic full
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    msg_t             entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(FIFO_DEPTH));
    assign pop_msg = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_msg;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("queue count overflow");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

endmodule

### src/mnre_back.sv
// Back end: serializes queued messages into output bytes.
`timescale 1ns / 1ps

module mnre_back
    import mnre_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fifo_empty,
    input  msg_t       fifo_msg,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] midi_byte,
    output logic       last
);

    msg_t       msg_reg;
    logic       busy_reg;
    logic [1:0] pos_reg;
    logic       done;

    assign out_valid = busy_reg;
    assign last      = (pos_reg == 2'd2) || (pos_reg == 2'd1 && msg_reg.two_bytes);
    assign done      = out_ready && last;
    assign pop       = !fifo_empty && (!busy_reg || done);

    always_comb begin
        case (pos_reg)
            2'd0:    midi_byte = msg_reg.status;
            2'd1:    midi_byte = {1'b0, msg_reg.data1};
            default: midi_byte = {1'b0, msg_reg.data2};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
        end else if (pop) begin
            busy_reg <= 1'b1;
            pos_reg  <= '0;
        end else if (busy_reg && out_ready) begin
            if (last) begin
                busy_reg <= 1'b0;
                pos_reg  <= '0;
            end else begin
                pos_reg <= pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (pop) begin
            msg_reg <= fifo_msg;
        end
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> pos_reg != 2'd3)
        else $error("byte position out of range");

endmodule

### src/midi_note_refcount_encoder.sv
// Top level: MIDI channel message encoder with per-key note counting.
// Path of a request word: front (counter lookup), queue, back (byte serializer).
// Flow: the front takes no request while in its lookup (counter read, then write-back);
// bytes leave one a cycle while out_ready is high; a full queue also blocks requests.
// Reset: counters read as zero through per-key valid bits cleared at once; no sweep.
// Reset also sets the counted channel to 0 and empties the message queue.
`timescale 1ns / 1ps

module midi_note_refcount_encoder
    import mnre_pkg::*;
#(
    parameter int KEY_COUNT = KEY_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [CHAN_W-1:0]  cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         mode,
    input  logic [CHAN_W-1:0]  channel,
    input  logic [KEY_W-1:0]   key,
    input  logic [VALUE_W-1:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         midi_byte,
    output logic               last
);

    logic fifo_push;
    logic fifo_pop;
    logic fifo_empty;
    logic fifo_full;
    msg_t push_msg;
    msg_t pop_msg;

    mnre_front #(
        .KEY_COUNT (KEY_COUNT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .channel     (channel),
        .key         (key),
        .value       (value),
        .fifo_full   (fifo_full),
        .push        (fifo_push),
        .push_msg    (push_msg)
    );

    mnre_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fifo_push),
        .push_msg (push_msg),
        .pop      (fifo_pop),
        .pop_msg  (pop_msg),
        .empty    (fifo_empty),
        .full     (fifo_full)
    );

    mnre_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .fifo_msg   (pop_msg),
        .pop        (fifo_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .midi_byte  (midi_byte),
        .last       (last)
    );

endmodule

### bench/midi_note_refcount_encoder_chk.sv
// Checker for the MIDI note encoder: predicts the bytes of each request and compares them.
`timescale 1ns / 1ps

module midi_note_refcount_encoder_chk
    import mnre_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [CHAN_W-1:0]  cfg_wr_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         mode,
    input  logic [CHAN_W-1:0]  channel,
    input  logic [KEY_W-1:0]   key,
    input  logic [VALUE_W-1:0] value,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [7:0]         midi_byte,
    input  logic               last,
    output int                 errors,
    output int                 pending,
    output int                 bytes_checked
);

    typedef struct packed {
        logic [7:0] midi_byte;
        logic       last;
    } midi_word_t;

    midi_word_t         byte_q[$];
    midi_word_t         want;
    logic [COUNT_W-1:0] key_hold[KEY_COUNT_DEF];
    logic [CHAN_W-1:0]  counted_ch;
    int                 fail_n;
    int                 seen_n;

    function automatic void push_three(logic [7:0] status, logic [CHAN_W-1:0] ch,
                                       logic [KEY_W-1:0] k, logic [7:0] data_v);
        byte_q.push_back('{status | (8'(ch) & MASK_CHANNEL), 1'b0});
        byte_q.push_back('{8'(k) & MASK_DATA, 1'b0});
        byte_q.push_back('{data_v, 1'b1});
    endfunction

    function automatic void encode_request(logic [1:0] m, logic [CHAN_W-1:0] ch,
                                           logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v);
        logic       tracked;
        logic [7:0] data_v;
        tracked = (ch == counted_ch) && (int'(k) < KEY_COUNT_DEF);
        data_v  = 8'(v) & MASK_DATA;
        case (m)
            MODE_NOTE_ON:
            begin
                if (tracked && key_hold[k] != COUNT_MAX)
                    key_hold[k] = key_hold[k] + 1'b1;
                push_three(STATUS_NOTE_ON, ch, k, data_v);
            end
            MODE_NOTE_OFF:
            begin
                if (tracked && key_hold[k] != '0)
                    key_hold[k] = key_hold[k] - 1'b1;
                if (!tracked || key_hold[k] == '0)
                    push_three(STATUS_NOTE_OFF, ch, k, data_v);
            end
            MODE_PRESSURE:
            begin
                byte_q.push_back('{STATUS_PRESSURE | (8'(ch) & MASK_CHANNEL), 1'b0});
                byte_q.push_back('{data_v, 1'b1});
            end
            default:
            begin
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_q.delete();
            foreach (key_hold[i])
                key_hold[i] = '0;
            counted_ch    = '0;
            fail_n        = 0;
            seen_n        = 0;
            errors        <= 0;
            pending       <= 0;
            bytes_checked <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                seen_n++;
                if (byte_q.size() == 0)
                begin
                    fail_n++;
                    if (fail_n <= 10)
                        $display("unexpected word: byte %02h last %0b, nothing expected",
                                 midi_byte, last);
                end
                else
                begin
                    want = byte_q.pop_front();
                    if (want.midi_byte !== midi_byte || want.last !== last)
                    begin
                        fail_n++;
                        if (fail_n <= 10)
                            $display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                                     want.midi_byte, want.last, midi_byte, last);
                    end
                end
            end
            if (in_valid && in_ready)
                encode_request(mode, channel, key, value);
            if (cfg_wr_en)
                counted_ch = cfg_wr_data;
            errors        <= fail_n;
            pending       <= byte_q.size();
            bytes_checked <= seen_n;
        end
    end

endmodule

### bench/midi_note_refcount_encoder_tb.sv
// Testbench top for the MIDI note encoder: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module midi_note_refcount_encoder_tb;
    import mnre_pkg::*;

    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT   = 200000;
    localparam int         SETTLE_CYCLES = 12;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [CHAN_W-1:0]  cfg_wr_data = '0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic [1:0]         mode        = '0;
    logic [CHAN_W-1:0]  channel     = '0;
    logic [KEY_W-1:0]   key         = '0;
    logic [VALUE_W-1:0] value       = '0;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic [7:0]         midi_byte;
    logic               last;

    int                 errors;
    int                 pending;
    int                 bytes_checked;

    logic               idle_on     = 1'b1;
    int                 stall_left  = 0;
    int                 cycles      = 0;
    int                 words_sent  = 0;
    logic [CHAN_W-1:0]  counted_now = '0;
    logic [CHAN_W-1:0]  chan_mid    = '0;
    logic [KEY_W-1:0]   key_pool[4] = '{7'd0, 7'd60, 7'd85, 7'd127};

    midi_note_refcount_encoder uut (.*);

    midi_note_refcount_encoder_chk chk (.*);

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("midi_note_refcount_encoder_tb: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!idle_on)
        begin
            out_ready  <= 1'b1;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end
        else
            out_ready <= 1'b1;
    end

    task automatic send_word(input logic [1:0] m, input logic [CHAN_W-1:0] ch,
                             input logic [KEY_W-1:0] k, input logic [VALUE_W-1:0] v);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        channel  <= ch;
        key      <= k;
        value    <= v;
        do @(posedge clk); while (!in_ready);
        words_sent++;
    endtask

    task automatic settle_block();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_counted(input logic [CHAN_W-1:0] ch);
        settle_block();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ch;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        counted_now = ch;
    endtask

    task automatic random_requests(input int n);
        int               pick;
        logic [1:0]       m;
        logic [CHAN_W-1:0] ch;
        logic [KEY_W-1:0] k;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 8)
                m = MODE_NOTE_ON;
            else if (pick < 16)
                m = MODE_NOTE_OFF;
            else if (pick < 19)
                m = MODE_PRESSURE;
            else
                m = MODE_UNUSED;
            ch = ($urandom_range(0, 3) != 0) ? counted_now : CHAN_W'($urandom);
            k  = ($urandom_range(0, 3) != 0) ? key_pool[$urandom_range(0, 3)]
                                             : KEY_W'($urandom);
            send_word(m, ch, k, VALUE_W'($urandom));
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // counted channel 0 from reset
        send_word(MODE_NOTE_ON,  4'd0,  7'd0,   8'h00);
        send_word(MODE_NOTE_ON,  4'd0,  7'd0,   8'hFF);
        send_word(MODE_NOTE_OFF, 4'd0,  7'd0,   8'h7F);
        send_word(MODE_NOTE_OFF, 4'd0,  7'd0,   8'h80);
        send_word(MODE_NOTE_OFF, 4'd0,  7'd0,   8'h01);
        send_word(MODE_NOTE_ON,  4'd15, 7'd127, 8'h7F);
        send_word(MODE_NOTE_OFF, 4'd15, 7'd127, 8'h80);
        send_word(MODE_PRESSURE, 4'd0,  7'd0,   8'hFF);
        send_word(MODE_PRESSURE, 4'd15, 7'd127, 8'h00);
        send_word(MODE_UNUSED,   4'd5,  7'd55,  8'hAA);
        send_word(MODE_UNUSED,   4'd0,  7'd0,   8'h00);
        send_word(MODE_NOTE_ON,  4'd0,  7'd127, 8'h80);
        send_word(MODE_NOTE_ON,  4'd0,  7'd127, 8'h55);
        send_word(MODE_NOTE_OFF, 4'd0,  7'd127, 8'h2A);
        send_word(MODE_PRESSURE, 4'd0,  7'd127, 8'h7F);
        send_word(MODE_NOTE_OFF, 4'd0,  7'd127, 8'hFF);
        send_word(MODE_NOTE_OFF, 4'd10, 7'd42,  8'h33);
        send_word(MODE_NOTE_ON,  4'd0,  7'd1,   8'h40);
        send_word(MODE_NOTE_OFF, 4'd0,  7'd1,   8'h41);
        send_word(MODE_NOTE_OFF, 4'd0,  7'd1,   8'h42);

        // stack note-ons on one key, then release it fully
        for (int i = 0; i < 8; i++)
            send_word(MODE_NOTE_ON, 4'd0, 7'd33, VALUE_W'($urandom));
        for (int i = 0; i < 8; i++)
            send_word(MODE_NOTE_OFF, 4'd0, 7'd33, VALUE_W'($urandom));

        write_counted(4'd15);
        random_requests(15);
        settle_block();
        random_requests(15);

        chan_mid = CHAN_W'($urandom_range(1, 14));
        write_counted(chan_mid);
        random_requests(25);

        write_counted(4'd0);
        idle_on <= 1'b0;
        random_requests(20);

        settle_block();
        $display("Run covered %0d requests (directed, stacked key, random) and %0d bytes.",
                 words_sent, bytes_checked);
        $display("Counted channel went 0, 15, %0d, 0; idling on both sides, then none at the end.",
                 chan_mid);
        if (errors == 0 && pending == 0)
            $display("midi_note_refcount_encoder_tb: PASS");
        else
            $display("midi_note_refcount_encoder_tb: FAIL");
        $finish;
    end

endmodule

### filelist.f
src/mnre_pkg.sv
src/mnre_front.sv
src/mnre_fifo.sv
src/mnre_back.sv
src/midi_note_refcount_encoder.sv
bench/midi_note_refcount_encoder_chk.sv
bench/midi_note_refcount_encoder_tb.sv
